// ===== rtl/core/mmcrc_pkg.sv =====
package mmcrc_pkg;

    // Mode register codes
    typedef logic [2:0] mode_t;

    localparam mode_t MODE_BCC   = 3'd0;
    localparam mode_t MODE_LRC   = 3'd1;
    localparam mode_t MODE_REF31 = 3'd2;
    localparam mode_t MODE_REF07 = 3'd3;
    localparam mode_t MODE_ITU   = 3'd4;
    localparam mode_t MODE_CRC8  = 3'd5;

    // Configuration register indexes
    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t CFG_MODE = 1'b0;
    localparam cfg_index_t CFG_SEED = 1'b1;

    typedef logic [7:0] byte_t;

    // Polynomial and final-step constants
    localparam byte_t RPOLY_31   = 8'h8C;
    localparam byte_t RPOLY_07   = 8'hE0;
    localparam byte_t NPOLY_07   = 8'h07;
    localparam byte_t ITU_XOROUT = 8'h55;
    localparam byte_t ONE        = 8'h01;
    localparam byte_t MSB_MASK   = 8'h80;

endpackage

// ===== rtl/core/mmcrc_msg_if.sv =====
interface mmcrc_msg_if;
    import mmcrc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/mmcrc_result_if.sv =====
interface mmcrc_result_if;
    import mmcrc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// ===== rtl/core/mmcrc_fold.sv =====
module mmcrc_fold (
    input  mmcrc_pkg::mode_t mode,
    input  mmcrc_pkg::byte_t acc,
    input  mmcrc_pkg::byte_t data_byte,
    output mmcrc_pkg::byte_t next_value,
    output mmcrc_pkg::byte_t checksum
);
    import mmcrc_pkg::*;

    // Shift eight bits through a reflected CRC register
    function automatic byte_t crc_reflected(input byte_t v_in, input byte_t rpoly);
        byte_t v;
        v = v_in;
        for (int k = 0; k < 8; k++) begin
            if ((v & ONE) != 8'h00)
                v = (v >> 1) ^ rpoly;
            else
                v = v >> 1;
        end
        return v;
    endfunction

    // Shift eight bits through a normal CRC register
    function automatic byte_t crc_normal(input byte_t v_in, input byte_t poly);
        byte_t v;
        v = v_in;
        for (int k = 0; k < 8; k++) begin
            if ((v & MSB_MASK) != 8'h00)
                v = (v << 1) ^ poly;
            else
                v = v << 1;
        end
        return v;
    endfunction

    byte_t mixed;

    assign mixed = acc ^ data_byte;

    // Fold the byte into the running value
    always_comb
    begin
        unique case (mode) inside
            MODE_LRC:             next_value = acc + data_byte;
            MODE_REF31:           next_value = crc_reflected(mixed, RPOLY_31);
            MODE_REF07:           next_value = crc_reflected(mixed, RPOLY_07);
            MODE_ITU, MODE_CRC8:  next_value = crc_normal(mixed, NPOLY_07);
            default:              next_value = mixed;
        endcase
    end

    // Apply the final negate or XOR
    always_comb
    begin
        unique case (mode) inside
            MODE_LRC: checksum = (~next_value) + ONE;
            MODE_ITU: checksum = next_value ^ ITU_XOROUT;
            default:  checksum = next_value;
        endcase
    end

endmodule

// ===== rtl/core/multi_mode_crc8_checksum.sv =====
// Path: a last byte accepted into the input register is folded there, and its
// checksum is then registered in the output register, from which it is taken.
// Throughput: one byte per cycle; a last byte waits in the input register only
// while the previous checksum is still untaken at the output register.
// Reset: rst_n is asynchronous and active low; it empties both registers,
// clears mode and seed to zero and makes the next byte start a message.
module multi_mode_crc8_checksum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  mmcrc_pkg::cfg_index_t   wr_index,
    input  mmcrc_pkg::byte_t        wr_data,
    mmcrc_msg_if.sink               msg,
    mmcrc_result_if.source          result
);
    import mmcrc_pkg::*;

    mode_t mode_reg;
    byte_t seed_reg;
    byte_t running_reg;
    logic  in_msg_reg;

    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_last_reg;

    logic  out_valid_reg;
    byte_t out_sum_reg;

    logic  s1_advance;
    byte_t start_value;
    byte_t fold_next;
    byte_t fold_sum;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BCC;
            seed_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_MODE: mode_reg <= wr_data[2:0];
                CFG_SEED: seed_reg <= wr_data;
                default:  ;
            endcase
        end
    end

    // Advance the held item unless it is a last byte blocked at the output
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign msg.ready  = !s1_valid_reg || s1_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (msg.ready)
            s1_valid_reg <= msg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            s1_byte_reg <= msg.data_byte;
            s1_last_reg <= msg.last_byte;
        end
    end

    // Restart from the seed at a message start
    assign start_value = in_msg_reg ? running_reg : seed_reg;

    mmcrc_fold u_fold (
        .mode       (mode_reg),
        .acc        (start_value),
        .data_byte  (s1_byte_reg),
        .next_value (fold_next),
        .checksum   (fold_sum)
    );

    // Running check state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            in_msg_reg  <= 1'b0;
        end
        else if (s1_advance)
        begin
            running_reg <= fold_next;
            in_msg_reg  <= !s1_last_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
            out_sum_reg <= fold_sum;
    end

    assign result.valid    = out_valid_reg;
    assign result.checksum = out_sum_reg;

endmodule

// ===== rtl/core/mmcrc_checker.sv =====
module mmcrc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             msg_valid,
    input logic             msg_ready,
    input logic             msg_last,
    input logic             res_valid,
    input logic             res_ready,
    input mmcrc_pkg::byte_t res_checksum
);
    import mmcrc_pkg::*;

    logic msg_take_last;

    assign msg_take_last = msg_valid && msg_ready && msg_last;

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_checksum))
        else $error("stalled checksum changed");

    // A fresh result is preceded by a taken last byte
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(msg_take_last, 2))
        else $error("result without a last byte");

    // A taken last byte leads to its result showing
    a_res_latency: assert property (@(posedge clk) disable iff (!rst_n)
        msg_take_last |-> ##2 res_valid)
        else $error("last byte produced no result");

endmodule

bind multi_mode_crc8_checksum mmcrc_checker u_mmcrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .msg_last     (msg.last_byte),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_checksum (result.checksum)
);
